// ===== sv/rsie_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the register/stack instruction executor.
package rsie_pkg;

    localparam int DATA_W          = 32;
    localparam int OPCODE_W        = 4;
    localparam int REG_FIELD_W     = 6;
    localparam int SLOT_FIELD_W    = 8;
    localparam int NUM_REGS_DEF    = 64;
    localparam int STACK_DEPTH_DEF = 256;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PRINT = 4'd0,
        OP_IMM   = 4'd1,
        OP_STORE = 4'd2,
        OP_LOAD  = 4'd3,
        OP_ADD   = 4'd4,
        OP_SUB   = 4'd5,
        OP_MUL   = 4'd6,
        OP_DIV   = 4'd7,
        OP_MOD   = 4'd8
    } opcode_t;

    // Request from the sequencer to the divider
    typedef struct packed {
        logic start;
        logic is_mod;
    } div_ctrl_t;

endpackage

// ===== sv/rsie_regfile.sv =====
`timescale 1ns / 1ps
// Register file memory: one write port, two registered read ports.
module rsie_regfile
    import rsie_pkg::*;
#(
    parameter int DEPTH = NUM_REGS_DEF,
    parameter int AW    = $clog2(NUM_REGS_DEF)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [AW-1:0]     rd_addr_a,
    input  logic [AW-1:0]     rd_addr_b,
    output logic [DATA_W-1:0] rd_data_a,
    output logic [DATA_W-1:0] rd_data_b
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ===== sv/rsie_stack.sv =====
`timescale 1ns / 1ps
// Stack memory: one write port, one registered read port.
module rsie_stack
    import rsie_pkg::*;
#(
    parameter int DEPTH = STACK_DEPTH_DEF,
    parameter int AW    = $clog2(STACK_DEPTH_DEF)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [AW-1:0]     rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== sv/rsie_divider.sv =====
`timescale 1ns / 1ps
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module rsie_divider
    import rsie_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  div_ctrl_t         ctrl,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic [DATA_W-1:0] result,
    output logic              done
);

    localparam int CNT_W = $clog2(DATA_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_FIX
    } div_state_t;

    div_state_t        state_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W:0]   rem_reg;
    logic [DATA_W-1:0] den_reg;
    logic              q_neg_reg;
    logic              r_neg_reg;
    logic              mod_reg;
    logic [DATA_W-1:0] result_reg;
    logic              done_reg;

    logic [DATA_W-1:0] abs_dividend;
    logic [DATA_W-1:0] abs_divisor;
    logic [DATA_W:0]   rem_shift;
    logic [DATA_W:0]   rem_diff;

    always_comb
    begin
        abs_dividend = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
        abs_divisor  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
        rem_shift    = {rem_reg[DATA_W-1:0], quo_reg[DATA_W-1]};
        rem_diff     = rem_shift - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    if (ctrl.start)
                    begin
                        quo_reg   <= abs_dividend;
                        den_reg   <= abs_divisor;
                        rem_reg   <= '0;
                        q_neg_reg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
                        r_neg_reg <= dividend[DATA_W-1];
                        mod_reg   <= ctrl.is_mod;
                        cnt_reg   <= '0;
                        state_reg <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    // restore when the trial subtract goes negative
                    if (rem_diff[DATA_W])
                    begin
                        rem_reg <= rem_shift;
                        quo_reg <= {quo_reg[DATA_W-2:0], 1'b0};
                    end
                    else
                    begin
                        rem_reg <= rem_diff;
                        quo_reg <= {quo_reg[DATA_W-2:0], 1'b1};
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_LAST)
                    begin
                        state_reg <= D_FIX;
                    end
                end
                D_FIX:
                begin
                    if (mod_reg)
                    begin
                        result_reg <= r_neg_reg ? (~rem_reg[DATA_W-1:0] + 1'b1)
                                                : rem_reg[DATA_W-1:0];
                    end
                    else
                    begin
                        result_reg <= q_neg_reg ? (~quo_reg + 1'b1) : quo_reg;
                    end
                    done_reg  <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

    a_done_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == D_IDLE)
        else $error("divider done outside idle");

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.start && state_reg == D_IDLE) |=> state_reg == D_RUN)
        else $error("divider did not start");

    a_last_step_fix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == D_RUN && cnt_reg == CNT_LAST) |=> state_reg == D_FIX)
        else $error("divider missed sign fix");

endmodule

// ===== sv/register_stack_instruction_executor.sv =====
`timescale 1ns / 1ps
// Top level: instruction sequencer over the register file, stack and divider.
//
// Usage:
//   Drive opcode, dest_reg, src_a, src_b, slot and immediate and raise start.
//   The item is taken at the rising edge where start is high and busy is low.
//   Exactly one result comes back per item: done is high for one cycle, and
//   print_valid, print_value and div_zero are valid in that same cycle.
//   Print, immediate, store, load, add and sub go through the read and
//   exec states; mul adds a multiply state; div and mod wait in the divide
//   state unless the divisor is zero. busy drops in the cycle that done is
//   shown, so items can run back to back. The registered register file
//   read sets the short path, the bit-serial divider (32 steps plus load
//   and sign fix) sets the long one.
//   One item is in flight at a time, so every write lands before the next
//   item reads and no forwarding is needed.
//   Reset clears the sequencer and the divider; register and stack contents
//   are undefined until written. The receiver cannot stall: a done pulse
//   must be sampled in its cycle.
module register_stack_instruction_executor
    import rsie_pkg::*;
#(
    parameter int NUM_REGS    = NUM_REGS_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [OPCODE_W-1:0]      opcode,
    input  logic [REG_FIELD_W-1:0]   dest_reg,
    input  logic [REG_FIELD_W-1:0]   src_a,
    input  logic [REG_FIELD_W-1:0]   src_b,
    input  logic [SLOT_FIELD_W-1:0]  slot,
    input  logic signed [DATA_W-1:0] immediate,
    output logic                     done,
    output logic                     print_valid,
    output logic signed [DATA_W-1:0] print_value,
    output logic                     div_zero
);

    localparam int REG_AW   = $clog2(NUM_REGS);
    localparam int STK_AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int REG_CODES  = 1 << REG_FIELD_W;
    localparam int SLOT_CODES = 1 << SLOT_FIELD_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_MUL,
        S_DIV
    } seq_state_t;

    // field value to memory index, wrapping at the memory depth
    logic [REG_AW-1:0] reg_map  [REG_CODES];
    logic [STK_AW-1:0] slot_map [SLOT_CODES];

    for (genvar i = 0; i < REG_CODES; i++)
    begin : g_reg_map
        assign reg_map[i] = REG_AW'(i % NUM_REGS);
    end

    for (genvar j = 0; j < SLOT_CODES; j++)
    begin : g_slot_map
        assign slot_map[j] = STK_AW'(j % STACK_DEPTH);
    end

    seq_state_t        state_reg;
    seq_state_t        state_next;
    opcode_t           op_reg;
    logic [REG_AW-1:0] dest_idx_reg;
    logic [REG_AW-1:0] a_idx_reg;
    logic [REG_AW-1:0] b_idx_reg;
    logic [STK_AW-1:0] slot_idx_reg;
    logic [DATA_W-1:0] imm_reg;
    logic [DATA_W-1:0] prod_reg;
    logic              done_reg;
    logic              print_valid_reg;
    logic [DATA_W-1:0] print_value_reg;
    logic              div_zero_reg;

    logic              accept;
    logic [REG_AW-1:0] rd_addr_a;
    logic [DATA_W-1:0] rd_a;
    logic [DATA_W-1:0] rd_b;
    logic [DATA_W-1:0] stk_rd;
    logic              rf_wr_en;
    logic [DATA_W-1:0] rf_wr_data;
    logic              stk_wr_en;
    logic              divisor_zero;
    div_ctrl_t         div_ctrl;
    logic [DATA_W-1:0] div_result;
    logic              div_done;

    assign accept       = start && (state_reg == S_IDLE);
    assign busy         = (state_reg != S_IDLE);
    assign divisor_zero = (rd_b == '0);
    // print and store read the destination register through port A
    assign rd_addr_a    = (op_reg == OP_PRINT || op_reg == OP_STORE) ? dest_idx_reg : a_idx_reg;

    always_comb
    begin
        state_next      = state_reg;
        rf_wr_en        = 1'b0;
        rf_wr_data      = rd_a + rd_b;
        stk_wr_en       = 1'b0;
        div_ctrl.start  = 1'b0;
        div_ctrl.is_mod = (op_reg == OP_MOD);
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                case (op_reg)
                    OP_IMM:
                    begin
                        rf_wr_en   = 1'b1;
                        rf_wr_data = imm_reg;
                    end
                    OP_STORE:
                    begin
                        stk_wr_en = 1'b1;
                    end
                    OP_LOAD:
                    begin
                        rf_wr_en   = 1'b1;
                        rf_wr_data = stk_rd;
                    end
                    OP_ADD:
                    begin
                        rf_wr_en = 1'b1;
                    end
                    OP_SUB:
                    begin
                        rf_wr_en   = 1'b1;
                        rf_wr_data = rd_a - rd_b;
                    end
                    OP_MUL:
                    begin
                        state_next = S_MUL;
                    end
                    OP_DIV, OP_MOD:
                    begin
                        if (!divisor_zero)
                        begin
                            div_ctrl.start = 1'b1;
                            state_next     = S_DIV;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_MUL:
            begin
                rf_wr_en   = 1'b1;
                rf_wr_data = prod_reg;
                state_next = S_IDLE;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    rf_wr_en   = 1'b1;
                    rf_wr_data = div_result;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            done_reg        <= 1'b0;
            print_valid_reg <= 1'b0;
            print_value_reg <= '0;
            div_zero_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            done_reg        <= 1'b0;
            print_valid_reg <= 1'b0;
            print_value_reg <= '0;
            div_zero_reg    <= 1'b0;
            if (accept)
            begin
                op_reg       <= opcode_t'(opcode);
                dest_idx_reg <= reg_map[dest_reg];
                a_idx_reg    <= reg_map[src_a];
                b_idx_reg    <= reg_map[src_b];
                slot_idx_reg <= slot_map[slot];
                imm_reg      <= $unsigned(immediate);
            end
            if (state_reg == S_EXEC)
            begin
                prod_reg <= rd_a * rd_b;
            end
            // raise the result strobe on the edge that returns to idle
            if (state_reg != S_IDLE && state_next == S_IDLE)
            begin
                done_reg <= 1'b1;
                if (state_reg == S_EXEC && op_reg == OP_PRINT)
                begin
                    print_valid_reg <= 1'b1;
                    print_value_reg <= rd_a;
                end
                if (state_reg == S_EXEC && (op_reg == OP_DIV || op_reg == OP_MOD))
                begin
                    div_zero_reg <= divisor_zero;
                end
            end
        end
    end

    assign done        = done_reg;
    assign print_valid = print_valid_reg;
    assign print_value = $signed(print_value_reg);
    assign div_zero    = div_zero_reg;

    rsie_regfile #(
        .DEPTH (NUM_REGS),
        .AW    (REG_AW)
    ) u_regfile (
        .clk       (clk),
        .wr_en     (rf_wr_en),
        .wr_addr   (dest_idx_reg),
        .wr_data   (rf_wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (b_idx_reg),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    rsie_stack #(
        .DEPTH (STACK_DEPTH),
        .AW    (STK_AW)
    ) u_stack (
        .clk     (clk),
        .wr_en   (stk_wr_en),
        .wr_addr (slot_idx_reg),
        .wr_data (rd_a),
        .rd_addr (slot_idx_reg),
        .rd_data (stk_rd)
    );

    rsie_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (rd_a),
        .divisor  (rd_b),
        .result   (div_result),
        .done     (div_done)
    );

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted item did not raise busy");

    a_fields_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> (!print_valid && !div_zero && print_value_reg == '0))
        else $error("result fields active without strobe");

    a_print_excl: assert property (@(posedge clk) disable iff (!rst_n)
        print_valid |-> !div_zero)
        else $error("print and divide error together");

    a_div_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && !div_done) |=> state_reg == S_DIV)
        else $error("left divide wait early");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench for the register/stack instruction executor: directed and random items with a scoreboard.
module tb;
    import rsie_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_UNUSED_LO = 4'd9;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_HI = 4'd15;
    localparam logic signed [DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] MOST_POS = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] MINUS_ONE = -32'sd1;
    localparam int RANDOM_ITEMS = 1600;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic                     print_valid;
        logic signed [DATA_W-1:0] print_value;
        logic                     div_zero;
    } exec_result_t;

    class executor_scoreboard;
        logic signed [DATA_W-1:0] regs [NUM_REGS_DEF];
        logic signed [DATA_W-1:0] stack [STACK_DEPTH_DEF];
        exec_result_t expected_results [$];
        int mismatch_count;

        function new();
            mismatch_count = 0;
            foreach (regs[i]) regs[i] = '0;
            foreach (stack[i]) stack[i] = '0;
        endfunction

        // Apply one accepted instruction to the shadow state and queue its result.
        function void note_instruction(logic [OPCODE_W-1:0] op, logic [REG_FIELD_W-1:0] d,
                                       logic [REG_FIELD_W-1:0] a, logic [REG_FIELD_W-1:0] b,
                                       logic [SLOT_FIELD_W-1:0] s,
                                       logic signed [DATA_W-1:0] imm);
            exec_result_t r;
            logic signed [DATA_W-1:0] x;
            logic signed [DATA_W-1:0] y;
            r.print_valid = 1'b0;
            r.print_value = '0;
            r.div_zero    = 1'b0;
            x = regs[a];
            y = regs[b];
            case (op)
                OP_PRINT:
                begin
                    r.print_valid = 1'b1;
                    r.print_value = regs[d];
                end
                OP_IMM:   regs[d] = imm;
                OP_STORE: stack[s] = regs[d];
                OP_LOAD:  regs[d] = stack[s];
                OP_ADD:   regs[d] = x + y;
                OP_SUB:   regs[d] = x - y;
                OP_MUL:   regs[d] = x * y;
                OP_DIV, OP_MOD:
                begin
                    if (y == 0)
                        r.div_zero = 1'b1;
                    else if (x == MOST_NEG && y == MINUS_ONE)
                        regs[d] = (op == OP_DIV) ? MOST_NEG : '0;
                    else
                        regs[d] = (op == OP_DIV) ? x / y : x % y;
                end
                default: ;
            endcase
            expected_results.push_back(r);
        endfunction

        function void check_result(logic pv, logic signed [DATA_W-1:0] val, logic dz);
            exec_result_t e;
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with no item pending (print_valid %b value %h div_zero %b)",
                         $realtime, pv, val, dz);
                mismatch_count++;
                return;
            end
            e = expected_results.pop_front();
            if (pv !== e.print_valid)
            begin
                $display("%0t: print_valid expected %b actual %b", $realtime, e.print_valid, pv);
                mismatch_count++;
            end
            if (val !== e.print_value)
            begin
                $display("%0t: print_value expected %h actual %h", $realtime, e.print_value, val);
                mismatch_count++;
            end
            if (dz !== e.div_zero)
            begin
                $display("%0t: div_zero expected %b actual %b", $realtime, e.div_zero, dz);
                mismatch_count++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [OPCODE_W-1:0]      opcode;
    logic [REG_FIELD_W-1:0]   dest_reg;
    logic [REG_FIELD_W-1:0]   src_a;
    logic [REG_FIELD_W-1:0]   src_b;
    logic [SLOT_FIELD_W-1:0]  slot;
    logic signed [DATA_W-1:0] immediate;
    logic                     done;
    logic                     print_valid;
    logic signed [DATA_W-1:0] print_value;
    logic                     div_zero;

    executor_scoreboard sb;
    bit reg_written [NUM_REGS_DEF];
    bit slot_written [STACK_DEPTH_DEF];
    int items_issued = 0;

    register_stack_instruction_executor DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #15ms;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            sb.check_result(print_valid, print_value, div_zero);
    end

    // Only registers and slots already written are ever read.
    function automatic logic [REG_FIELD_W-1:0] pick_reg();
        logic [REG_FIELD_W-1:0] r;
        r = REG_FIELD_W'($urandom);
        while (!reg_written[r])
            r = REG_FIELD_W'($urandom);
        return r;
    endfunction

    function automatic logic [SLOT_FIELD_W-1:0] pick_slot();
        logic [SLOT_FIELD_W-1:0] s;
        s = SLOT_FIELD_W'($urandom);
        while (!slot_written[s])
            s = SLOT_FIELD_W'($urandom);
        return s;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 32'sd1;
            2: return MINUS_ONE;
            3: return MOST_NEG;
            4: return MOST_POS;
            5: return $signed($urandom_range(0, 40)) - 32'sd20;
            default: return $urandom;
        endcase
    endfunction

    task automatic issue(logic [OPCODE_W-1:0] op, logic [REG_FIELD_W-1:0] d,
                         logic [REG_FIELD_W-1:0] a, logic [REG_FIELD_W-1:0] b,
                         logic [SLOT_FIELD_W-1:0] s, logic signed [DATA_W-1:0] imm);
        bit divisor_nonzero;
        int gap;
        int roll;
        divisor_nonzero = (sb.regs[b] != 0);
        @(negedge clk);
        start     <= 1'b1;
        opcode    <= op;
        dest_reg  <= d;
        src_a     <= a;
        src_b     <= b;
        slot      <= s;
        immediate <= imm;
        do
            @(posedge clk);
        while (busy);
        sb.note_instruction(op, d, a, b, s, imm);
        case (op)
            OP_IMM, OP_LOAD, OP_ADD, OP_SUB, OP_MUL: reg_written[d] = 1'b1;
            OP_DIV, OP_MOD: if (divisor_nonzero) reg_written[d] = 1'b1;
            OP_STORE: slot_written[s] = 1'b1;
            default: ;
        endcase
        items_issued++;
        // Run back to back in every fourth stretch of 150 items.
        if ((items_issued / 150) % 4 == 2)
            gap = 0;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
                gap = 0;
            else if (roll < 85)
                gap = $urandom_range(1, 3);
            else if (roll < 97)
                gap = $urandom_range(4, 12);
            else
                gap = $urandom_range(20, 60);
        end
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    initial
    begin
        logic [REG_FIELD_W-1:0]   d;
        logic [REG_FIELD_W-1:0]   a;
        logic [REG_FIELD_W-1:0]   b;
        logic [REG_FIELD_W-1:0]   ra;
        logic [REG_FIELD_W-1:0]   rb;
        logic [SLOT_FIELD_W-1:0]  s;
        logic signed [DATA_W-1:0] v;
        logic signed [DATA_W-1:0] divisor;
        int kind;
        int base;

        sb = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        opcode    = '0;
        dest_reg  = '0;
        src_a     = '0;
        src_b     = '0;
        slot      = '0;
        immediate = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, overflow, zero divisor, most negative by minus one.
        issue(OP_IMM, 0, 0, 0, 0, MOST_NEG);
        issue(OP_IMM, 63, 0, 0, 0, MOST_POS);
        issue(OP_IMM, 1, 0, 0, 0, MINUS_ONE);
        issue(OP_IMM, 2, 0, 0, 0, '0);
        issue(OP_IMM, 3, 0, 0, 0, 32'sd1);
        issue(OP_PRINT, 0, 0, 0, 0, '0);
        issue(OP_PRINT, 63, 0, 0, 0, '0);
        issue(OP_ADD, 4, 63, 3, 0, '0);
        issue(OP_SUB, 5, 0, 3, 0, '0);
        issue(OP_MUL, 6, 63, 63, 0, '0);
        issue(OP_DIV, 7, 0, 1, 0, '0);
        issue(OP_MOD, 8, 0, 1, 0, '0);
        issue(OP_DIV, 3, 63, 2, 0, '0);
        issue(OP_MOD, 3, 0, 2, 0, '0);
        issue(OP_STORE, 0, 0, 0, 255, '0);
        issue(OP_STORE, 63, 0, 0, 0, '0);
        issue(OP_LOAD, 10, 0, 0, 255, '0);
        issue(OP_LOAD, 11, 0, 0, 0, '0);
        issue(OP_PRINT, 4, 0, 0, 0, '0);
        issue(OP_PRINT, 7, 0, 0, 0, '0);
        issue(OP_PRINT, 8, 0, 0, 0, '0);
        issue(OP_PRINT, 3, 0, 0, 0, '0);
        issue(OP_PRINT, 10, 0, 0, 0, '0);
        issue(OP_UNUSED_LO, 0, 0, 0, 0, '0);
        issue(OP_UNUSED_HI, 63, 63, 63, 255, MINUS_ONE);

        base = items_issued;
        while (items_issued - base < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            d = REG_FIELD_W'($urandom);
            a = pick_reg();
            b = pick_reg();
            s = pick_slot();
            v = $urandom;
            if (kind < 22)
                issue(OP_PRINT, pick_reg(), a, b, s, v);
            else if (kind < 36)
                issue(OP_IMM, d, a, b, s, pick_value());
            else if (kind < 44)
                issue(OP_STORE, pick_reg(), a, b, SLOT_FIELD_W'($urandom), v);
            else if (kind < 50)
                issue(OP_LOAD, d, a, b, s, v);
            else if (kind < 58)
                issue(OP_ADD, d, a, b, s, v);
            else if (kind < 64)
                issue(OP_SUB, d, a, b, s, v);
            else if (kind < 72)
                issue(OP_MUL, d, a, b, s, v);
            else if (kind < 92)
            begin
                // Aim at a register holding zero now and then.
                if ($urandom_range(0, 5) == 0)
                    for (int i = 0; i < NUM_REGS_DEF; i++)
                        if (reg_written[i] && sb.regs[i] == 0)
                            b = REG_FIELD_W'(i);
                issue((kind < 82) ? OP_DIV : OP_MOD, d, a, b, s, v);
            end
            else if (kind < 95)
                issue(OPCODE_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), d, a, b,
                      SLOT_FIELD_W'($urandom), v);
            else
            begin
                // Load both operands, divide, then print the destination if it was ever written.
                ra = REG_FIELD_W'($urandom);
                rb = REG_FIELD_W'($urandom);
                if (rb == ra)
                    rb = ra ^ REG_FIELD_W'(1);
                case ($urandom_range(0, 2))
                    0:       divisor = MINUS_ONE;
                    1:       divisor = '0;
                    default: divisor = pick_value();
                endcase
                issue(OP_IMM, ra, a, b, s, $urandom_range(0, 1) ? MOST_NEG : pick_value());
                issue(OP_IMM, rb, a, b, s, divisor);
                issue($urandom_range(0, 1) ? OP_DIV : OP_MOD, d, ra, rb, s, v);
                if (reg_written[d])
                    issue(OP_PRINT, d, a, b, s, v);
            end
        end

        @(negedge clk);
        start <= 1'b0;
        for (int i = 0; i < 200 && sb.expected_results.size() != 0; i++)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.expected_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $realtime, sb.expected_results.size());
            sb.mismatch_count++;
        end
        if (sb.mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
